FILE: hw/rtl/mpq_pkg.sv
// Shared types and constants for the min priority queue core.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package mpq_pkg;

    localparam int KEY_W       = 64;
    localparam int PORT_PRIO_W = 16;
    localparam int TOTAL_W     = 5;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_CHANGE  = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_EMPTY     = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SCAN_DEQ,
        ST_SHIFT,
        ST_SCAN_CHG,
        ST_SCAN_HEAD,
        ST_DONE
    } state_t;

    typedef struct packed {
        cmd_t                           cmd;
        logic [KEY_W-1:0]               key;
        logic signed [PORT_PRIO_W-1:0]  priority_req;
    } req_t;

    typedef struct packed {
        status_t                        status;
        logic [KEY_W-1:0]               out_key;
        logic signed [PORT_PRIO_W-1:0]  out_priority;
        logic [KEY_W-1:0]               head_key;
        logic signed [PORT_PRIO_W-1:0]  head_priority;
        logic [TOTAL_W-1:0]             entry_total;
    } rsp_t;

    // Per-cycle commands broadcast from the sequencer to every cell
    typedef struct packed {
        logic write_en;     // enqueue: the cell at the fill index loads
        logic shift_en;     // dequeue: cells at or above the head index take their neighbor
        logic change_mode;  // scan wave also carries the first-match token
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mpq_stream_if.sv
// Valid/ready channel carrying one payload per transaction.
// Payload type is set by the instantiating level (mpq_pkg::req_t or rsp_t).
`default_nettype none

interface mpq_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mpq_cell.sv
// One storage cell of the queue: holds a key and priority, takes part in
// the compare wave and the shift on removal. Depends on mpq_pkg.
`default_nettype none

module mpq_cell #(
    parameter int CAPACITY  = 16,
    parameter int PRIO_BITS = 16,
    parameter int INDEX     = 0,
    localparam int CNTW     = $clog2(CAPACITY + 1),
    localparam int IDXW     = $clog2(CAPACITY)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mpq_pkg::cell_ctrl_t                ctrl,
    input  logic [CNTW-1:0]                    fill_count,
    input  logic [IDXW-1:0]                    head_idx,
    input  logic [mpq_pkg::KEY_W-1:0]          new_key,
    input  logic signed [PRIO_BITS-1:0]        new_prio,
    input  logic [mpq_pkg::KEY_W-1:0]          nbr_key,
    input  logic signed [PRIO_BITS-1:0]        nbr_prio,
    output logic [mpq_pkg::KEY_W-1:0]          own_key,
    output logic signed [PRIO_BITS-1:0]        own_prio,
    input  logic                               in_vld,
    input  logic                               in_has,
    input  logic                               in_found,
    input  logic [mpq_pkg::KEY_W-1:0]          in_key,
    input  logic signed [PRIO_BITS-1:0]        in_prio,
    input  logic [IDXW-1:0]                    in_idx,
    output logic                               out_vld,
    output logic                               out_has,
    output logic                               out_found,
    output logic [mpq_pkg::KEY_W-1:0]          out_key,
    output logic signed [PRIO_BITS-1:0]        out_prio,
    output logic [IDXW-1:0]                    out_idx
);

    logic [mpq_pkg::KEY_W-1:0]   key_reg;
    logic signed [PRIO_BITS-1:0] prio_reg;

    logic                        vld_reg;
    logic                        has_reg;
    logic                        found_reg;
    logic [mpq_pkg::KEY_W-1:0]   best_key_reg;
    logic signed [PRIO_BITS-1:0] best_prio_reg;
    logic [IDXW-1:0]             best_idx_reg;

    logic occupied;
    logic better;
    logic take;
    logic hit;

    assign occupied = CNTW'(INDEX) < fill_count;
    // strict compare: an earlier equal entry keeps the lead
    assign better   = !in_has || (prio_reg < in_prio) ||
                      ((prio_reg == in_prio) && (key_reg < in_key));
    assign take     = occupied && better;
    assign hit      = ctrl.change_mode && in_vld && !in_found && occupied &&
                      (key_reg == new_key);

    always_ff @(posedge clk)
    begin
        if (ctrl.write_en && (CNTW'(INDEX) == fill_count))
        begin
            key_reg  <= new_key;
            prio_reg <= new_prio;
        end
        else if (ctrl.shift_en && (head_idx <= IDXW'(INDEX)))
        begin
            key_reg  <= nbr_key;
            prio_reg <= nbr_prio;
        end
        else if (hit)
        begin
            prio_reg <= new_prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= 1'b0;
            has_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            vld_reg   <= in_vld;
            has_reg   <= in_has || take;
            found_reg <= in_found || hit;
        end
    end

    always_ff @(posedge clk)
    begin
        best_key_reg  <= take ? key_reg : in_key;
        best_prio_reg <= take ? prio_reg : in_prio;
        best_idx_reg  <= take ? IDXW'(INDEX) : in_idx;
    end

    assign own_key   = key_reg;
    assign own_prio  = prio_reg;
    assign out_vld   = vld_reg;
    assign out_has   = has_reg;
    assign out_found = found_reg;
    assign out_key   = best_key_reg;
    assign out_prio  = best_prio_reg;
    assign out_idx   = best_idx_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/min_priority_queue_core.sv
// Min priority queue core: a row of CAPACITY cells with a systolic compare wave.
// Sequence: accept, apply, then a compare wave that finds the head for enqueue and clear;
// dequeue runs a search wave and a shift first, and change priority a match wave (two waves).
// Throughput: one transaction in flight; the wave crossing the cell row sets it.
// Reset: rst_n clears the sequencer, the fill count and the result valid; cell
// contents stay undefined until written. Depends on mpq_pkg, mpq_stream_if, mpq_cell.
`default_nettype none

module min_priority_queue_core #(
    parameter int CAPACITY  = 16,
    parameter int PRIO_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    mpq_stream_if.sink        req,
    mpq_stream_if.source      rsp
);

    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int IDXW = $clog2(CAPACITY);
    localparam int KW   = mpq_pkg::KEY_W;
    localparam int PW   = mpq_pkg::PORT_PRIO_W;
    localparam int TW   = mpq_pkg::TOTAL_W;

    // ------------------------------------------------------------------
    // Sequencer and result registers
    // ------------------------------------------------------------------
    mpq_pkg::state_t     state_reg, state_next;
    logic                start_reg, start_next;
    logic [CNTW-1:0]     count_reg, count_next;
    logic                rsp_vld_reg, rsp_vld_next;
    mpq_pkg::rsp_t       rsp_payload_reg, rsp_payload_next;

    mpq_pkg::status_t    status_reg, status_next;
    logic [KW-1:0]       rem_key_reg, rem_key_next;
    logic [PRIO_BITS-1:0] rem_prio_reg, rem_prio_next;
    logic [IDXW-1:0]     head_idx_reg, head_idx_next;
    logic                head_has_reg, head_has_next;
    logic [KW-1:0]       head_key_reg, head_key_next;
    logic [PRIO_BITS-1:0] head_prio_reg, head_prio_next;

    // latched request
    mpq_pkg::cmd_t       cmd_reg;
    logic [KW-1:0]       key_reg;
    logic [PW-1:0]       prio_req_reg;

    mpq_pkg::cell_ctrl_t ctrl;
    logic                req_fire;

    // priority field conversions: the port is read as a PRIO_BITS pattern,
    // and a stored priority is reported as its low port-width bits, zero padded
    logic [PW+PRIO_BITS-1:0]    req_prio_wide;
    logic signed [PRIO_BITS-1:0] new_prio;
    logic [PRIO_BITS+PW-1:0]    head_prio_wide;
    logic [PRIO_BITS+PW-1:0]    rem_prio_wide;
    logic [CNTW+TW-1:0]         count_wide;

    assign req_prio_wide  = {{PRIO_BITS{1'b0}}, prio_req_reg};
    assign new_prio       = req_prio_wide[PRIO_BITS-1:0];
    assign head_prio_wide = {{PW{1'b0}}, head_prio_reg};
    assign rem_prio_wide  = {{PW{1'b0}}, rem_prio_reg};
    assign count_wide     = {{TW{1'b0}}, count_reg};

    // ------------------------------------------------------------------
    // Cell row: wave signals run from index 0 to CAPACITY
    // ------------------------------------------------------------------
    logic                        wave_vld   [0:CAPACITY];
    logic                        wave_has   [0:CAPACITY];
    logic                        wave_found [0:CAPACITY];
    logic [KW-1:0]               wave_key   [0:CAPACITY];
    logic signed [PRIO_BITS-1:0] wave_prio  [0:CAPACITY];
    logic [IDXW-1:0]             wave_idx   [0:CAPACITY];

    logic [KW-1:0]               cell_key   [0:CAPACITY-1];
    logic signed [PRIO_BITS-1:0] cell_prio  [0:CAPACITY-1];

    // launch the wave with an empty best and no match seen
    assign wave_vld[0]   = start_reg;
    assign wave_has[0]   = 1'b0;
    assign wave_found[0] = 1'b0;
    assign wave_key[0]   = '0;
    assign wave_prio[0]  = '0;
    assign wave_idx[0]   = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KW-1:0]               nbr_key;
        logic signed [PRIO_BITS-1:0] nbr_prio;

        // the last cell has no neighbor above; it holds its own contents
        if (i == CAPACITY - 1)
        begin : g_last
            assign nbr_key  = cell_key[i];
            assign nbr_prio = cell_prio[i];
        end
        else
        begin : g_mid
            assign nbr_key  = cell_key[i+1];
            assign nbr_prio = cell_prio[i+1];
        end

        mpq_cell #(
            .CAPACITY  (CAPACITY),
            .PRIO_BITS (PRIO_BITS),
            .INDEX     (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .fill_count (count_reg),
            .head_idx   (head_idx_reg),
            .new_key    (key_reg),
            .new_prio   (new_prio),
            .nbr_key    (nbr_key),
            .nbr_prio   (nbr_prio),
            .own_key    (cell_key[i]),
            .own_prio   (cell_prio[i]),
            .in_vld     (wave_vld[i]),
            .in_has     (wave_has[i]),
            .in_found   (wave_found[i]),
            .in_key     (wave_key[i]),
            .in_prio    (wave_prio[i]),
            .in_idx     (wave_idx[i]),
            .out_vld    (wave_vld[i+1]),
            .out_has    (wave_has[i+1]),
            .out_found  (wave_found[i+1]),
            .out_key    (wave_key[i+1]),
            .out_prio   (wave_prio[i+1]),
            .out_idx    (wave_idx[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign req.ready   = (state_reg == mpq_pkg::ST_IDLE);
    assign req_fire    = req.valid && req.ready;
    assign rsp.valid   = rsp_vld_reg;
    assign rsp.payload = rsp_payload_reg;

    // ------------------------------------------------------------------
    // Next state and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        start_next       = 1'b0;
        count_next       = count_reg;
        status_next      = status_reg;
        rem_key_next     = rem_key_reg;
        rem_prio_next    = rem_prio_reg;
        head_idx_next    = head_idx_reg;
        head_has_next    = head_has_reg;
        head_key_next    = head_key_reg;
        head_prio_next   = head_prio_reg;
        rsp_payload_next = rsp_payload_reg;
        rsp_vld_next     = rsp_vld_reg && !rsp.ready;
        ctrl             = '0;

        case (state_reg)
            mpq_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = mpq_pkg::ST_APPLY;
                end
            end

            mpq_pkg::ST_APPLY:
            begin
                status_next   = mpq_pkg::STS_OK;
                rem_key_next  = '0;
                rem_prio_next = '0;
                start_next    = 1'b1;
                state_next    = mpq_pkg::ST_SCAN_HEAD;
                case (cmd_reg)
                    mpq_pkg::CMD_ENQUEUE:
                    begin
                        if (count_reg == CNTW'(CAPACITY))
                        begin
                            status_next = mpq_pkg::STS_FULL;
                        end
                        else
                        begin
                            ctrl.write_en = 1'b1;
                            count_next    = count_reg + CNTW'(1);
                        end
                    end
                    mpq_pkg::CMD_DEQUEUE:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = mpq_pkg::STS_EMPTY;
                        end
                        else
                        begin
                            state_next = mpq_pkg::ST_SCAN_DEQ;
                        end
                    end
                    mpq_pkg::CMD_CHANGE:
                    begin
                        state_next = mpq_pkg::ST_SCAN_CHG;
                    end
                    default:
                    begin
                        // clear: drop every entry
                        count_next = '0;
                    end
                endcase
            end

            mpq_pkg::ST_SCAN_DEQ:
            begin
                // wave leaves the row with the earliest minimum
                if (wave_vld[CAPACITY])
                begin
                    head_idx_next = wave_idx[CAPACITY];
                    rem_key_next  = wave_key[CAPACITY];
                    rem_prio_next = wave_prio[CAPACITY];
                    state_next    = mpq_pkg::ST_SHIFT;
                end
            end

            mpq_pkg::ST_SHIFT:
            begin
                // close the gap left by the removed entry, then rescan
                ctrl.shift_en = 1'b1;
                count_next    = count_reg - CNTW'(1);
                start_next    = 1'b1;
                state_next    = mpq_pkg::ST_SCAN_HEAD;
            end

            mpq_pkg::ST_SCAN_CHG:
            begin
                ctrl.change_mode = 1'b1;
                if (wave_vld[CAPACITY])
                begin
                    status_next = wave_found[CAPACITY] ? mpq_pkg::STS_OK
                                                       : mpq_pkg::STS_NOT_FOUND;
                    start_next  = 1'b1;
                    state_next  = mpq_pkg::ST_SCAN_HEAD;
                end
            end

            mpq_pkg::ST_SCAN_HEAD:
            begin
                if (wave_vld[CAPACITY])
                begin
                    head_has_next  = wave_has[CAPACITY];
                    head_key_next  = wave_key[CAPACITY];
                    head_prio_next = wave_prio[CAPACITY];
                    state_next     = mpq_pkg::ST_DONE;
                end
            end

            mpq_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!rsp_vld_reg || rsp.ready)
                begin
                    rsp_vld_next                   = 1'b1;
                    rsp_payload_next.status        = status_reg;
                    rsp_payload_next.out_key       = rem_key_reg;
                    rsp_payload_next.out_priority  = rem_prio_wide[PW-1:0];
                    rsp_payload_next.head_key      = head_has_reg ? head_key_reg : '0;
                    rsp_payload_next.head_priority =
                        head_has_reg ? head_prio_wide[PW-1:0] : '0;
                    rsp_payload_next.entry_total   = count_wide[TW-1:0];
                    state_next                     = mpq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mpq_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mpq_pkg::ST_IDLE;
            start_reg   <= 1'b0;
            count_reg   <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            count_reg   <= count_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg      <= req.payload.cmd;
            key_reg      <= req.payload.key;
            prio_req_reg <= req.payload.priority_req;
        end
        status_reg      <= status_next;
        rem_key_reg     <= rem_key_next;
        rem_prio_reg    <= rem_prio_next;
        head_idx_reg    <= head_idx_next;
        head_has_reg    <= head_has_next;
        head_key_reg    <= head_key_next;
        head_prio_reg   <= head_prio_next;
        rsp_payload_reg <= rsp_payload_next;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(CAPACITY))
        else $error("fill count above capacity");

    a_enqueue_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mpq_pkg::ST_APPLY) && (cmd_reg == mpq_pkg::CMD_ENQUEUE) &&
        (count_reg != CNTW'(CAPACITY))
        |=> count_reg == CNTW'($past(count_reg) + CNTW'(1)))
        else $error("enqueue did not add one entry");

    a_shift_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mpq_pkg::ST_SHIFT) |-> (count_reg != '0)
        ##1 (count_reg == CNTW'($past(count_reg) - CNTW'(1))))
        else $error("removal did not drop one entry");

    a_wave_launch: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> (state_reg == mpq_pkg::ST_SCAN_DEQ) ||
                      (state_reg == mpq_pkg::ST_SCAN_CHG) ||
                      (state_reg == mpq_pkg::ST_SCAN_HEAD))
        else $error("compare wave launched outside a scan");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_vld_reg && (rsp_payload_reg.status == mpq_pkg::STS_EMPTY)
        |-> (rsp_payload_reg.out_key == '0) && (rsp_payload_reg.out_priority == '0))
        else $error("empty dequeue reported a removed entry");
`endif

endmodule

`default_nettype wire

FILE: verif/min_priority_queue_core_tb.sv
// Self-checking testbench for min_priority_queue_core: directed table, then random traffic.
// Results are predicted by a behavioral queue mirror kept inside this file.
// Depends on mpq_pkg, mpq_stream_if and the core itself.
`timescale 1ns / 1ps

module min_priority_queue_core_tb;

    localparam int CAPACITY        = 16;
    localparam int PRIO_BITS       = 16;
    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 12;
    // Generous limit: many times the worst-case transaction time, plus idling.
    localparam int CYCLE_LIMIT     = 600000;
    localparam int DRAIN_CYCLES    = 2 * CAPACITY + 6 + 20;
    localparam int RANDOM_ITEMS    = 1750;
    localparam int PHASES          = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PRESSURE_ITEMS  = 30;
    localparam int POOL_SIZE       = 8;
    localparam int DIRECTED_ROWS   = 17;
    localparam int KW              = mpq_pkg::KEY_W;
    localparam int PW              = mpq_pkg::PORT_PRIO_W;
    localparam int TW              = mpq_pkg::TOTAL_W;

    localparam logic [KW-1:0]        KEY_MAX  = '1;
    localparam logic signed [PW-1:0] PRIO_MIN = 16'sh8000;
    localparam logic signed [PW-1:0] PRIO_MAX = 16'sh7fff;

    // One row of the directed table. A row may repeat; with key_step set, the key
    // advances by one on each repetition. Rows with checked set carry the result
    // typed in by hand; all others are checked against the queue mirror.
    typedef struct {
        mpq_pkg::req_t item;
        int            reps;
        bit            key_step;
        bit            checked;
        mpq_pkg::rsp_t want;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #CLK_HALF clk = ~clk;

    mpq_stream_if #(.payload_t(mpq_pkg::req_t)) req_ch ();
    mpq_stream_if #(.payload_t(mpq_pkg::rsp_t)) rsp_ch ();

    min_priority_queue_core #(
        .CAPACITY  (CAPACITY),
        .PRIO_BITS (PRIO_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Mirror of the queue contents, kept in insertion order like the core.
    logic [KW-1:0]        mirror_keys  [CAPACITY];
    logic signed [PW-1:0] mirror_prios [CAPACITY];
    int unsigned          mirror_count;

    mpq_pkg::rsp_t expected_responses [$];
    int            mismatches;
    int            cycle_count;

    // Idling controls, changed only by the main sequence.
    int send_idle_pct;
    int rx_stall_pct;
    int hold_requests;

    // Side information for the transaction currently offered on req_ch.
    logic          cur_checked;
    mpq_pkg::rsp_t cur_want;

    logic [KW-1:0] key_pool [POOL_SIZE];

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // Dequeue on an empty queue: empty status, all zeros
        '{'{mpq_pkg::CMD_DEQUEUE, 64'd0, 16'sd0}, 1, 1'b0, 1'b1,
          '{mpq_pkg::STS_EMPTY, 64'd0, 16'sd0, 64'd0, 16'sd0, 5'd0}},
        // Change priority on an empty queue: not found
        '{'{mpq_pkg::CMD_CHANGE, 64'd5, 16'sd1}, 1, 1'b0, 1'b1,
          '{mpq_pkg::STS_NOT_FOUND, 64'd0, 16'sd0, 64'd0, 16'sd0, 5'd0}},
        // Clear while already empty
        '{'{mpq_pkg::CMD_CLEAR, KEY_MAX, PRIO_MAX}, 1, 1'b0, 1'b1,
          '{mpq_pkg::STS_OK, 64'd0, 16'sd0, 64'd0, 16'sd0, 5'd0}},
        // Largest key with the most negative priority becomes the head
        '{'{mpq_pkg::CMD_ENQUEUE, KEY_MAX, PRIO_MIN}, 1, 1'b0, 1'b1,
          '{mpq_pkg::STS_OK, 64'd0, 16'sd0, KEY_MAX, PRIO_MIN, 5'd1}},
        // Least urgent priority does not displace the head
        '{'{mpq_pkg::CMD_ENQUEUE, 64'd0, PRIO_MAX}, 1, 1'b0, 1'b1,
          '{mpq_pkg::STS_OK, 64'd0, 16'sd0, KEY_MAX, PRIO_MIN, 5'd2}},
        // Equal priority: the smaller key wins the tie
        '{'{mpq_pkg::CMD_ENQUEUE, 64'd0, PRIO_MIN}, 1, 1'b0, 1'b1,
          '{mpq_pkg::STS_OK, 64'd0, 16'sd0, 64'd0, PRIO_MIN, 5'd3}},
        // Fully equal duplicate; the earliest one must leave first
        '{'{mpq_pkg::CMD_ENQUEUE, 64'd0, PRIO_MIN}, 1, 1'b0, 1'b0, '0},
        '{'{mpq_pkg::CMD_DEQUEUE, 64'd0, 16'sd0}, 1, 1'b0, 1'b0, '0},
        // Key 0 appears twice; only the first match changes
        '{'{mpq_pkg::CMD_CHANGE, 64'd0, PRIO_MAX}, 1, 1'b0, 1'b0, '0},
        '{'{mpq_pkg::CMD_CHANGE, 64'h1234, 16'sd0}, 1, 1'b0, 1'b0, '0},
        '{'{mpq_pkg::CMD_DEQUEUE, 64'd0, 16'sd0}, 1, 1'b0, 1'b0, '0},
        // Clear a nonempty queue
        '{'{mpq_pkg::CMD_CLEAR, 64'd0, 16'sd0}, 1, 1'b0, 1'b1,
          '{mpq_pkg::STS_OK, 64'd0, 16'sd0, 64'd0, 16'sd0, 5'd0}},
        // Fill to capacity with keys 0..15, all at priority zero
        '{'{mpq_pkg::CMD_ENQUEUE, 64'd0, 16'sd0}, CAPACITY, 1'b1, 1'b0, '0},
        // Enqueue when full: full status, head is key 0
        '{'{mpq_pkg::CMD_ENQUEUE, 64'd99, -16'sd1}, 1, 1'b0, 1'b1,
          '{mpq_pkg::STS_FULL, 64'd0, 16'sd0, 64'd0, 16'sd0, 5'd16}},
        // Change the last entry so it becomes the head, then pull it out
        '{'{mpq_pkg::CMD_CHANGE, 64'd15, PRIO_MIN}, 1, 1'b0, 1'b0, '0},
        '{'{mpq_pkg::CMD_DEQUEUE, 64'd0, 16'sd0}, 1, 1'b0, 1'b0, '0},
        '{'{mpq_pkg::CMD_CLEAR, 64'd0, 16'sd0}, 1, 1'b0, 1'b1,
          '{mpq_pkg::STS_OK, 64'd0, 16'sd0, 64'd0, 16'sd0, 5'd0}}
    };

    // Index of the earliest most urgent entry; the mirror must be nonempty.
    function automatic int unsigned urgent_index();
        int unsigned best;
        best = 0;
        for (int unsigned i = 1; i < mirror_count; i++)
        begin
            if (mirror_prios[i] < mirror_prios[best] ||
                (mirror_prios[i] == mirror_prios[best] && mirror_keys[i] < mirror_keys[best]))
                best = i;
        end
        return best;
    endfunction

    // Apply one command to the mirror and return the response it must produce.
    function automatic mpq_pkg::rsp_t predict_response(mpq_pkg::req_t r);
        mpq_pkg::rsp_t res;
        int unsigned   h;
        bit            hit;
        res        = '0;
        res.status = mpq_pkg::STS_OK;
        hit        = 1'b0;
        case (r.cmd)
            mpq_pkg::CMD_ENQUEUE:
            begin
                if (mirror_count >= CAPACITY)
                    res.status = mpq_pkg::STS_FULL;
                else
                begin
                    mirror_keys[mirror_count]  = r.key;
                    mirror_prios[mirror_count] = r.priority_req;
                    mirror_count++;
                end
            end
            mpq_pkg::CMD_DEQUEUE:
            begin
                if (mirror_count == 0)
                    res.status = mpq_pkg::STS_EMPTY;
                else
                begin
                    h = urgent_index();
                    res.out_key      = mirror_keys[h];
                    res.out_priority = mirror_prios[h];
                    for (int unsigned i = h; i + 1 < mirror_count; i++)
                    begin
                        mirror_keys[i]  = mirror_keys[i + 1];
                        mirror_prios[i] = mirror_prios[i + 1];
                    end
                    mirror_count--;
                end
            end
            mpq_pkg::CMD_CHANGE:
            begin
                res.status = mpq_pkg::STS_NOT_FOUND;
                for (int unsigned i = 0; i < mirror_count; i++)
                begin
                    if (!hit && mirror_keys[i] == r.key)
                    begin
                        mirror_prios[i] = r.priority_req;
                        res.status      = mpq_pkg::STS_OK;
                        hit             = 1'b1;
                    end
                end
            end
            default:
                mirror_count = 0;
        endcase
        if (mirror_count > 0)
        begin
            h = urgent_index();
            res.head_key      = mirror_keys[h];
            res.head_priority = mirror_prios[h];
        end
        res.entry_total = TW'(mirror_count);
        return res;
    endfunction

    // Random command: biased toward enqueue so the queue often runs full, keys
    // mostly from a small pool or the live contents so changes hit, priorities
    // mostly in a narrow band so ties are common.
    function automatic mpq_pkg::req_t random_request();
        mpq_pkg::req_t r;
        int            sel;
        int            band;
        sel = $urandom_range(99);
        if (sel < 45)
            r.cmd = mpq_pkg::CMD_ENQUEUE;
        else if (sel < 75)
            r.cmd = mpq_pkg::CMD_DEQUEUE;
        else if (sel < 96)
            r.cmd = mpq_pkg::CMD_CHANGE;
        else
            r.cmd = mpq_pkg::CMD_CLEAR;
        sel = $urandom_range(99);
        if (sel < 55)
            r.key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else if (sel < 80 && mirror_count > 0)
            r.key = mirror_keys[$urandom_range(mirror_count - 1)];
        else
            r.key = {$urandom, $urandom};
        if ($urandom_range(99) < 70)
        begin
            band = int'($urandom_range(16)) - 8;
            r.priority_req = band[PW-1:0];
        end
        else
            r.priority_req = PW'($urandom);
        return r;
    endfunction

    task automatic report_field(string field, logic [KW-1:0] want, logic [KW-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Offer one transaction; return at the falling edge after it was accepted,
    // with valid still high so a back-to-back item needs no re-raise.
    task automatic send_item(mpq_pkg::req_t item, logic checked, mpq_pkg::rsp_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= item;
        cur_checked    <= checked;
        cur_want       <= want;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Drop valid and hold until every predicted response has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (expected_responses.size() != 0)
            @(negedge clk);
    endtask

    // Record the expectation for every accepted request. Hand-typed rows push
    // their typed result; the mirror still advances so later rows line up.
    always @(posedge clk)
    begin
        mpq_pkg::rsp_t predicted;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            predicted = predict_response(req_ch.payload);
            if (cur_checked)
                expected_responses.push_back(cur_want);
            else
                expected_responses.push_back(predicted);
        end
    end

    // Compare every accepted response against the oldest expectation.
    always @(posedge clk)
    begin
        mpq_pkg::rsp_t want;
        mpq_pkg::rsp_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.payload;
            if (expected_responses.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, actual %h", $time, got);
                mismatches++;
            end
            else
            begin
                want = expected_responses.pop_front();
                report_field("status", 64'(want.status), 64'(got.status));
                report_field("out_key", want.out_key, got.out_key);
                report_field("out_priority", 64'(want.out_priority), 64'(got.out_priority));
                report_field("head_key", want.head_key, got.head_key);
                report_field("head_priority", 64'(want.head_priority), 64'(got.head_priority));
                report_field("entry_total", 64'(want.entry_total), 64'(got.entry_total));
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here whenever the
    // main sequence asks for one.
    initial
    begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        mpq_pkg::req_t item;
        int            send_pcts  [PHASES] = '{0, 59, 0, 38};
        int            stall_pcts [PHASES] = '{0, 0, 59, 38};

        mismatches     = 0;
        mirror_count   = 0;
        send_idle_pct  = 0;
        rx_stall_pct   = 0;
        hold_requests  = 0;
        cur_checked    = 1'b0;
        cur_want       = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;

        // Hold reset, then release it away from the sampling edge.
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table, no idling on either side.
        foreach (directed_rows[r])
        begin
            for (int n = 0; n < directed_rows[r].reps; n++)
            begin
                item = directed_rows[r].item;
                if (directed_rows[r].key_step)
                    item.key = item.key + KW'(n);
                send_item(item, directed_rows[r].checked, directed_rows[r].want);
            end
        end
        wait_drained();

        // Random traffic through each idling phase. A fresh key pool per phase,
        // with the extreme keys always in it.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            send_idle_pct = send_pcts[ph];
            rx_stall_pct  = stall_pcts[ph];
            foreach (key_pool[i])
                key_pool[i] = {$urandom, $urandom};
            key_pool[0]             = '0;
            key_pool[POOL_SIZE - 1] = KEY_MAX;
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
                send_item(random_request(), 1'b0, '0);

            // After the first phase, hold the receiver off for a long stretch
            // while requests keep coming, so the input side backs up.
            if (ph == 0)
            begin
                hold_requests++;
                for (int n = 0; n < PRESSURE_ITEMS; n++)
                    send_item(random_request(), 1'b0, '0);
            end
            wait_drained();
        end

        // Let any stray response show up before the verdict.
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
